// ===== hdl/tcaf_pkg.sv =====
// shared types and constants for the two-class age-ordered fifo
package tcaf_pkg;

  // default sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_STAMP_BITS  = 16;
  localparam int DEF_TAG_BITS    = 16;

  // fixed field widths on the ports
  localparam int TAG_W   = 16;
  localparam int STAMP_W = 16;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // class codes
  localparam logic [1:0] CLS_A      = 2'd0;
  localparam logic [1:0] CLS_B      = 2'd1;
  localparam logic [1:0] CLS_EITHER = 2'd2;
  localparam logic [1:0] CLS_BAD    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_DEQ   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  typedef struct packed {
    logic             action;
    logic [1:0]       item_class;
    logic [TAG_W-1:0] item_tag;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               out_class;
    logic [TAG_W-1:0]   out_tag;
    logic [STAMP_W-1:0] out_stamp;
  } out_beat_t;

  // queue control and status
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== hdl/tcaf_queue.sv =====
// one class queue: entry store, head/tail/count and a prefetched head entry
module tcaf_queue #(
  parameter int QUEUE_DEPTH = tcaf_pkg::DEF_QUEUE_DEPTH,
  parameter int ENTRY_BITS  = tcaf_pkg::DEF_TAG_BITS + tcaf_pkg::DEF_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcaf_pkg::q_cmd_t      cmd,
  input  logic [ENTRY_BITS-1:0] wr_data,
  output logic [ENTRY_BITS-1:0] head_data,
  output tcaf_pkg::q_stat_t     stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_BITS-1:0] head_data_r;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_nxt  = cmd.pop  ? ptr_inc(head_r) : head_r;
    tail_nxt  = cmd.push ? ptr_inc(tail_r) : tail_r;
    count_nxt = count_r;
    if (cmd.push && !cmd.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop && !cmd.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // store write and head prefetch; a push into an empty queue lands on the next head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= wr_data;
    end
    if (cmd.push && (tail_r == head_nxt)) begin
      head_data_r <= wr_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign head_data  = head_data_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not advance count");
`endif

endmodule

// ===== hdl/two_class_age_ordered_fifo_unit.sv =====
// top level: command decode, arrival stamp counter and result register
// result: a result beat is registered and shown in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready is high; heads are prefetched into registers so a
//   dequeue only selects between two registered entries and one stamp subtract
// reset: both queues empty, arrival counter zero; entry store is not cleared
module two_class_age_ordered_fifo_unit #(
  parameter int QUEUE_DEPTH = tcaf_pkg::DEF_QUEUE_DEPTH,
  parameter int STAMP_BITS  = tcaf_pkg::DEF_STAMP_BITS,
  parameter int TAG_BITS    = tcaf_pkg::DEF_TAG_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcaf_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcaf_pkg::out_beat_t out_data
);

  localparam int ENTRY_BITS = TAG_BITS + STAMP_BITS;

  logic                  accept;
  logic                  out_valid_r;
  tcaf_pkg::out_beat_t   out_data_r;
  tcaf_pkg::out_beat_t   res;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic                  stamp_inc;

  tcaf_pkg::q_cmd_t      a_cmd, b_cmd;
  tcaf_pkg::q_stat_t     a_stat, b_stat;
  logic [ENTRY_BITS-1:0] a_head, b_head, wr_entry;
  logic [TAG_BITS-1:0]   tag_in, a_tag, b_tag;
  logic [STAMP_BITS-1:0] a_stamp, b_stamp, stamp_diff;
  logic                  a_older, sel_b, take_b;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign tag_in   = TAG_BITS'(in_data.item_tag);
  assign wr_entry = {tag_in, stamp_r};
  assign a_tag    = a_head[STAMP_BITS +: TAG_BITS];
  assign b_tag    = b_head[STAMP_BITS +: TAG_BITS];
  assign a_stamp  = a_head[STAMP_BITS-1:0];
  assign b_stamp  = b_head[STAMP_BITS-1:0];

  // a is older when b - a, modulo the stamp width, has its top bit clear
  assign stamp_diff = b_stamp - a_stamp;
  assign a_older    = !stamp_diff[STAMP_BITS-1];
  assign sel_b      = (in_data.item_class == tcaf_pkg::CLS_B);

  always_comb begin
    res       = '0;
    a_cmd     = '0;
    b_cmd     = '0;
    stamp_inc = 1'b0;
    take_b    = 1'b0;
    if (in_data.action == tcaf_pkg::ACT_ENQ) begin
      unique case (in_data.item_class) inside
        tcaf_pkg::CLS_A, tcaf_pkg::CLS_B: begin
          res.out_class = sel_b;
          if (sel_b ? b_stat.full : a_stat.full) begin
            res.status = tcaf_pkg::ST_ERR;
          end else begin
            res.status    = tcaf_pkg::ST_ENQ;
            res.out_tag   = tcaf_pkg::TAG_W'(tag_in);
            res.out_stamp = tcaf_pkg::STAMP_W'(stamp_r);
            a_cmd.push    = accept && !sel_b;
            b_cmd.push    = accept && sel_b;
            stamp_inc     = accept;
          end
        end
        default: begin
          res.status = tcaf_pkg::ST_ERR;
        end
      endcase
    end else begin
      unique case (in_data.item_class) inside
        tcaf_pkg::CLS_A, tcaf_pkg::CLS_B: begin
          res.out_class = sel_b;
          if (sel_b ? b_stat.empty : a_stat.empty) begin
            res.status = tcaf_pkg::ST_EMPTY;
          end else begin
            take_b     = sel_b;
            res.status = tcaf_pkg::ST_DEQ;
            a_cmd.pop  = accept && !sel_b;
            b_cmd.pop  = accept && sel_b;
          end
        end
        tcaf_pkg::CLS_EITHER: begin
          if (a_stat.empty && b_stat.empty) begin
            res.status = tcaf_pkg::ST_EMPTY;
          end else begin
            take_b        = a_stat.empty || (!b_stat.empty && !a_older);
            res.status    = tcaf_pkg::ST_DEQ;
            res.out_class = take_b;
            a_cmd.pop     = accept && !take_b;
            b_cmd.pop     = accept && take_b;
          end
        end
        default: begin
          res.status = tcaf_pkg::ST_ERR;
        end
      endcase
      if (res.status == tcaf_pkg::ST_DEQ) begin
        res.out_tag   = tcaf_pkg::TAG_W'(take_b ? b_tag : a_tag);
        res.out_stamp = tcaf_pkg::STAMP_W'(take_b ? b_stamp : a_stamp);
      end
    end
  end

  assign stamp_nxt = stamp_inc ? stamp_r + 1'b1 : stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stamp_r <= stamp_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcaf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_queue_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (a_cmd),
    .wr_data   (wr_entry),
    .head_data (a_head),
    .stat      (a_stat)
  );

  tcaf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_queue_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (b_cmd),
    .wr_data   (wr_entry),
    .head_data (b_head),
    .stat      (b_stat)
  );

`ifndef SYNTH
  a_one_queue_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({a_cmd.push, a_cmd.pop, b_cmd.push, b_cmd.pop}) <= 1)
    else $error("more than one queue operation in a cycle");

  a_stamp_on_enq: assert property (@(posedge clk) disable iff (!rst_n)
    stamp_inc |-> (a_cmd.push || b_cmd.push))
    else $error("stamp advanced without an enqueue");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");
`endif

endmodule
